// ===== src/akef_pkg.sv =====
// Shared types and constants of the action-change key event FIFO.
package akef_pkg;

  localparam int unsigned KEY_W         = 8;
  localparam int unsigned ACTIONS_W     = 6;
  localparam int unsigned COUNT_W       = 3;
  localparam int unsigned CFG_IDX_W     = 3;
  localparam int unsigned CFG_DATA_W    = 8;
  localparam int unsigned NUM_CODE_REGS = 6;
  localparam int unsigned CODE_IDX_W    = 3;
  localparam int unsigned CODE_SLOTS    = 8;

  localparam logic MODE_TICK = 1'b0;
  localparam logic MODE_POP  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_INTERVAL = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CODE_FORWARD    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CODE_BACKWARD   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CODE_TURN_LEFT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CODE_TURN_RIGHT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CODE_FIRE       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CODE_USE        = 3'd6;

  localparam logic [7:0]       INTERVAL_RESET   = 8'd4;
  localparam logic [KEY_W-1:0] CODE_FWD_RESET   = 8'd173;
  localparam logic [KEY_W-1:0] CODE_BACK_RESET  = 8'd175;
  localparam logic [KEY_W-1:0] CODE_LEFT_RESET  = 8'd172;
  localparam logic [KEY_W-1:0] CODE_RIGHT_RESET = 8'd174;
  localparam logic [KEY_W-1:0] CODE_FIRE_RESET  = 8'd163;
  localparam logic [KEY_W-1:0] CODE_USE_RESET   = 8'd162;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FIN
  } state_e;

  // Controller to datapath.
  typedef struct packed {
    logic accept;
    logic scan_step;
    logic load_out;
  } ctl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic start_scan;
    logic scan_last;
    logic out_free;
  } dp_sts_t;

endpackage

// ===== src/akef_if.sv =====
// Handshake interfaces for the input and result channels.
interface akef_in_if;
  logic                                valid;
  logic                                ready;
  logic                                mode;
  logic [akef_pkg::ACTIONS_W-1:0]      actions;

  modport source (output valid, output mode, output actions, input ready);
  modport sink   (input valid, input mode, input actions, output ready);
endinterface

interface akef_out_if #(
  parameter int unsigned LEVEL_W = 5
);
  logic                              valid;
  logic                              ready;
  logic                              event_valid;
  logic [akef_pkg::KEY_W-1:0]        event_key;
  logic                              event_pressed;
  logic                              sampled;
  logic [akef_pkg::COUNT_W-1:0]      pushed_count;
  logic [akef_pkg::COUNT_W-1:0]      dropped_count;
  logic [LEVEL_W-1:0]                queue_level;

  modport source (output valid, output event_valid, output event_key, output event_pressed,
                  output sampled, output pushed_count, output dropped_count,
                  output queue_level, input ready);
  modport sink   (input valid, input event_valid, input event_key, input event_pressed,
                  input sampled, input pushed_count, input dropped_count,
                  input queue_level, output ready);
endinterface

// ===== src/akef_ctrl.sv =====
// Controller state machine: accept, scan action bits, hand off the result word.
module akef_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  akef_pkg::dp_sts_t   sts_i,
  output akef_pkg::ctl_cmd_t  cmd_o
);

  akef_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= akef_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      akef_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = sts_i.start_scan ? akef_pkg::ST_SCAN : akef_pkg::ST_FIN;
        end
      end
      akef_pkg::ST_SCAN: begin
        if (sts_i.scan_last) begin
          state_d = akef_pkg::ST_FIN;
        end
      end
      akef_pkg::ST_FIN: begin
        if (sts_i.out_free) begin
          state_d = akef_pkg::ST_IDLE;
        end
      end
      default: state_d = akef_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o      = 1'b0;
    cmd_o           = '0;
    case (state_q)
      akef_pkg::ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      akef_pkg::ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
      end
      akef_pkg::ST_FIN: begin
        cmd_o.load_out = sts_i.out_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

// ===== src/akef_dp.sv =====
// Datapath: config registers, frame counter, event ring memory, result register.
module akef_dp #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned NUM_ACTIONS = 6,
  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
  localparam int unsigned LVL_W = $clog2(QUEUE_DEPTH + 1),
  localparam int unsigned IDX_W = (NUM_ACTIONS > 1) ? $clog2(NUM_ACTIONS) : 1
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [akef_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [akef_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                in_mode_i,
  input  logic [akef_pkg::ACTIONS_W-1:0]      in_actions_i,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output logic                                event_valid_o,
  output logic [akef_pkg::KEY_W-1:0]          event_key_o,
  output logic                                event_pressed_o,
  output logic                                sampled_o,
  output logic [akef_pkg::COUNT_W-1:0]        pushed_count_o,
  output logic [akef_pkg::COUNT_W-1:0]        dropped_count_o,
  output logic [LVL_W-1:0]                    queue_level_o,
  input  akef_pkg::ctl_cmd_t                  cmd_i,
  output akef_pkg::dp_sts_t                   sts_o
);

  localparam int unsigned ENTRY_W = akef_pkg::KEY_W + 1;

  // Config
  logic [7:0]                 interval_q;
  logic [akef_pkg::KEY_W-1:0] codes_q [akef_pkg::NUM_CODE_REGS];
  logic [akef_pkg::KEY_W-1:0] code_tab [akef_pkg::CODE_SLOTS];

  // Frame and scan state
  logic [7:0]             tick_q;
  logic [NUM_ACTIONS-1:0] prev_q, now_q, diff_q;
  logic [IDX_W-1:0]       idx_q;
  logic                   sampled_q, popv_q;
  logic [akef_pkg::COUNT_W-1:0] pushed_q, dropped_q;

  // Queue
  logic [PTR_W-1:0]   rd_ptr_q, wr_ptr_q;
  logic [LVL_W-1:0]   level_q;
  logic [ENTRY_W-1:0] mem [QUEUE_DEPTH];
  logic [ENTRY_W-1:0] rdata_q;

  // Result register
  logic                         out_valid_q;
  logic                         ev_valid_q, ev_pressed_q, ev_sampled_q;
  logic [akef_pkg::KEY_W-1:0]   ev_key_q;
  logic [akef_pkg::COUNT_W-1:0] ev_pushed_q, ev_dropped_q;
  logic [LVL_W-1:0]             ev_level_q;

  logic [8:0]             tick_next;
  logic                   sample_now;
  logic [7:0]             act_ext;
  logic [NUM_ACTIONS-1:0] act_now;
  logic                   full, empty;
  logic                   mem_we, mem_re;
  logic [akef_pkg::CODE_IDX_W-1:0] code_idx;

  assign tick_next  = {1'b0, tick_q} + 9'd1;
  assign sample_now = (in_mode_i == akef_pkg::MODE_TICK) && (tick_next >= {1'b0, interval_q});
  assign act_ext    = 8'(in_actions_i);
  assign act_now    = act_ext[NUM_ACTIONS-1:0];
  assign full       = (level_q == LVL_W'(QUEUE_DEPTH));
  assign empty      = (level_q == '0);
  assign mem_we     = cmd_i.scan_step && diff_q[idx_q] && !full;
  assign mem_re     = cmd_i.accept && (in_mode_i == akef_pkg::MODE_POP) && !empty;
  assign code_idx   = akef_pkg::CODE_IDX_W'(idx_q);

  always_comb begin
    for (int k = 0; k < akef_pkg::CODE_SLOTS; k++) begin
      code_tab[k] = (k < akef_pkg::NUM_CODE_REGS) ? codes_q[k] : '0;
    end
  end

  assign sts_o.start_scan = sample_now;
  assign sts_o.scan_last  = (idx_q == IDX_W'(NUM_ACTIONS - 1));
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q <= akef_pkg::INTERVAL_RESET;
      codes_q[0] <= akef_pkg::CODE_FWD_RESET;
      codes_q[1] <= akef_pkg::CODE_BACK_RESET;
      codes_q[2] <= akef_pkg::CODE_LEFT_RESET;
      codes_q[3] <= akef_pkg::CODE_RIGHT_RESET;
      codes_q[4] <= akef_pkg::CODE_FIRE_RESET;
      codes_q[5] <= akef_pkg::CODE_USE_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        akef_pkg::REG_SAMPLE_INTERVAL: interval_q <= cfg_data_i;
        akef_pkg::REG_CODE_FORWARD:    codes_q[0] <= cfg_data_i;
        akef_pkg::REG_CODE_BACKWARD:   codes_q[1] <= cfg_data_i;
        akef_pkg::REG_CODE_TURN_LEFT:  codes_q[2] <= cfg_data_i;
        akef_pkg::REG_CODE_TURN_RIGHT: codes_q[3] <= cfg_data_i;
        akef_pkg::REG_CODE_FIRE:       codes_q[4] <= cfg_data_i;
        akef_pkg::REG_CODE_USE:        codes_q[5] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q    <= '0;
      prev_q    <= '0;
      now_q     <= '0;
      diff_q    <= '0;
      idx_q     <= '0;
      sampled_q <= 1'b0;
      popv_q    <= 1'b0;
      pushed_q  <= '0;
      dropped_q <= '0;
      rd_ptr_q  <= '0;
      wr_ptr_q  <= '0;
      level_q   <= '0;
    end else if (cmd_i.accept) begin
      pushed_q  <= '0;
      dropped_q <= '0;
      idx_q     <= '0;
      if (in_mode_i == akef_pkg::MODE_POP) begin
        sampled_q <= 1'b0;
        popv_q    <= !empty;
        if (!empty) begin
          rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
          level_q  <= level_q - 1'b1;
        end
      end else begin
        popv_q    <= 1'b0;
        sampled_q <= sample_now;
        if (sample_now) begin
          tick_q <= '0;
          now_q  <= act_now;
          diff_q <= act_now ^ prev_q;
          prev_q <= act_now;
        end else begin
          tick_q <= tick_next[7:0];
        end
      end
    end else if (cmd_i.scan_step) begin
      idx_q <= idx_q + 1'b1;
      if (diff_q[idx_q]) begin
        if (full) begin
          dropped_q <= dropped_q + 1'b1;
        end else begin
          pushed_q <= pushed_q + 1'b1;
          level_q  <= level_q + 1'b1;
          wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_ptr_q] <= {code_tab[code_idx], now_q[idx_q]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      rdata_q <= mem[rd_ptr_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      ev_valid_q   <= popv_q;
      ev_key_q     <= popv_q ? rdata_q[ENTRY_W-1:1] : '0;
      ev_pressed_q <= popv_q ? rdata_q[0] : 1'b0;
      ev_sampled_q <= sampled_q;
      ev_pushed_q  <= pushed_q;
      ev_dropped_q <= dropped_q;
      ev_level_q   <= level_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign event_valid_o   = ev_valid_q;
  assign event_key_o     = ev_key_q;
  assign event_pressed_o = ev_pressed_q;
  assign sampled_o       = ev_sampled_q;
  assign pushed_count_o  = ev_pushed_q;
  assign dropped_count_o = ev_dropped_q;
  assign queue_level_o   = ev_level_q;

  a_no_write_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (level_q != LVL_W'(QUEUE_DEPTH)))
    else $error("event write into a full queue");

  a_no_read_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_re |-> (level_q != '0))
    else $error("event read from an empty queue");

  a_level_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    level_q <= LVL_W'(QUEUE_DEPTH))
    else $error("queue level beyond depth");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten while held");

endmodule

// ===== src/action_change_key_event_fifo.sv =====
// Top level of the action-change key event FIFO.
//
//   channel  direction  handshake      word
//   in_i     sink       valid/ready    mode, actions
//   out_o    source     valid/ready    event_valid .. queue_level
//   cfg      write      cfg_we_i       cfg_idx_i, cfg_data_i
//
// A pop or a non-sampling tick goes from accept to the final state, where the result
// register is loaded; a sampling tick first passes through the scan state, where the
// controller scans one action bit per cycle into the ring.
// The result register lets the next word be accepted while a result waits.
// Reset clears counters, pointers and fill level; the ring needs no clear.
// A stalled result holds the controller in its final state until taken.
module action_change_key_event_fifo #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned NUM_ACTIONS = 6
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [akef_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [akef_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  akef_in_if.sink                          in_i,
  akef_out_if.source                       out_o
);

  akef_pkg::ctl_cmd_t cmd;
  akef_pkg::dp_sts_t  sts;

  // Sequence each word: accept, scan changed bits, load the result.
  akef_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Hold config, counter, ring and result register.
  akef_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .NUM_ACTIONS (NUM_ACTIONS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .in_mode_i       (in_i.mode),
    .in_actions_i    (in_i.actions),
    .out_ready_i     (out_o.ready),
    .out_valid_o     (out_o.valid),
    .event_valid_o   (out_o.event_valid),
    .event_key_o     (out_o.event_key),
    .event_pressed_o (out_o.event_pressed),
    .sampled_o       (out_o.sampled),
    .pushed_count_o  (out_o.pushed_count),
    .dropped_count_o (out_o.dropped_count),
    .queue_level_o   (out_o.queue_level),
    .cmd_i           (cmd),
    .sts_o           (sts)
  );

endmodule
